FILE: sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator: heap geometry,
// request/result payloads, controller states and the command/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    // Heap geometry: 16-byte units, one header unit in front of every block
    localparam int HEAP_UNITS = 16384;
    localparam int UNIT_W     = $clog2(HEAP_UNITS);
    localparam int LINK_W     = UNIT_W + 1;
    localparam int UNIT_SHIFT = 4;

    // Payload field widths
    localparam int BYTES_W = 19;
    localparam int OFFS_W  = 18;
    localparam int NEED_W  = BYTES_W + 1 - UNIT_SHIFT;
    localparam int CALC_W  = NEED_W + 1;
    localparam int FUNIT_W = OFFS_W - UNIT_SHIFT;

    // Link value that ends the free list
    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(HEAP_UNITS);

    // Header of unit 0 after reset: the whole heap as one free block
    localparam logic [UNIT_W-1:0] SIZE0_RESET = UNIT_W'(HEAP_UNITS - 1);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_BADFREE = 2'd2
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTES_W-1:0]  request_bytes;
        logic [OFFS_W-1:0]   payload_offset;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [OFFS_W-1:0]   granted_offset;
    } out_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_SPLIT,
        S_LINK,
        S_FREE_CHK,
        S_DONE
    } state_t;

    // Controller to datapath (and output register)
    typedef struct packed {
        logic    clr_en;
        logic    latch;
        logic    walk_start;
        logic    walk_next;
        logic    commit_a;
        logic    commit_b;
        logic    free_rd;
        logic    free_commit;
        logic    res_we;
        status_t res_status;
        logic    res_grant;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic off_zero;
        logic off_bad;
        logic walk_end;
        logic fits;
        logic mark_set;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over a heap of 16-byte units with a LIFO free list,
// block split on allocate and in-use checking on free.
//
//   channel  dir  handshake           payload
//   s_       in   s_valid / s_ready   ffha_pkg::in_item_t  (kind, bytes, offset)
//   m_       out  m_valid / m_ready   ffha_pkg::out_item_t (status, offset)
//
// Allocate: the request is decoded, the free list is walked from its head
// until an entry fits or the walk ends, then the block is split and marked
// and the list relinked; the walk reads one header a cycle from the header
// memory's single read port. Free: one mark memory read, then the check.
// After reset the in-use marks are cleared one unit a cycle, all HEAP_UNITS
// (16384) units with s_ready low. One request is in flight at a time; a
// finished result waits in the output register while the next request is
// taken, and a stalled m_ready holds the following result in the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ffha_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ffha_pkg::out_item_t       m_data
);

    ffha_pkg::dp_cmd_t   cmd;
    ffha_pkg::dp_sts_t   sts;
    ffha_pkg::out_item_t res_data;

    logic                m_valid_reg;
    logic                m_valid_next;
    ffha_pkg::out_item_t m_data_reg;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .s_ready  (s_ready)
    );

    ffha_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (res_data)
    );

    // Output register: load a finished result, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sv/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath
// Header and in-use mark memories, free-list head, list walk registers and
// the result register of the heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ffha_pkg::in_item_t   s_data,
    input  wire ffha_pkg::dp_cmd_t    cmd,
    output ffha_pkg::dp_sts_t         sts,
    output ffha_pkg::out_item_t       res_data
);

    // Header memories (size and link split so either can be written alone)
    logic [ffha_pkg::UNIT_W-1:0] size_mem [ffha_pkg::HEAP_UNITS];
    logic [ffha_pkg::LINK_W-1:0] link_mem [ffha_pkg::HEAP_UNITS];
    logic                        mark_mem [ffha_pkg::HEAP_UNITS];

    // Request registers
    ffha_pkg::kind_t              kind_reg;
    logic [ffha_pkg::NEED_W-1:0]  need_reg;
    logic [ffha_pkg::NEED_W-1:0]  need_next;
    logic [ffha_pkg::OFFS_W-1:0]  offset_reg;
    logic [ffha_pkg::BYTES_W:0]   bytes_round;

    // Walk registers
    logic [ffha_pkg::LINK_W-1:0]  cur_reg;
    logic [ffha_pkg::LINK_W-1:0]  cur_next;
    logic [ffha_pkg::LINK_W-1:0]  prev_reg;
    logic [ffha_pkg::LINK_W-1:0]  step_reg;
    logic [ffha_pkg::LINK_W-1:0]  repl_reg;
    logic                         split_reg;
    logic [ffha_pkg::LINK_W-1:0]  free_head_reg;
    logic [ffha_pkg::UNIT_W-1:0]  clr_cnt_reg;
    logic                         size0_set_reg;
    logic                         link0_set_reg;

    // Registered read data
    logic [ffha_pkg::UNIT_W-1:0]  size_rd_reg;
    logic [ffha_pkg::LINK_W-1:0]  link_rd_reg;
    logic                         mark_rd_reg;

    // Result register
    ffha_pkg::status_t            res_status_reg;
    logic [ffha_pkg::OFFS_W-1:0]  res_offset_reg;

    // Combinational helpers
    logic                         rd_en;
    logic [ffha_pkg::UNIT_W-1:0]  rd_addr;
    logic [ffha_pkg::FUNIT_W-1:0] funit;
    logic [ffha_pkg::UNIT_W-1:0]  funit_addr;
    logic [ffha_pkg::CALC_W-1:0]  rem_unit;
    logic                         split;
    logic [ffha_pkg::UNIT_W-1:0]  rem_addr;
    logic [ffha_pkg::LINK_W-1:0]  cur_plus1;
    logic [ffha_pkg::OFFS_W-1:0]  grant_off;

    logic                         size_we;
    logic [ffha_pkg::UNIT_W-1:0]  size_waddr;
    logic [ffha_pkg::UNIT_W-1:0]  size_wdata;
    logic                         link_we;
    logic [ffha_pkg::UNIT_W-1:0]  link_waddr;
    logic [ffha_pkg::LINK_W-1:0]  link_wdata;
    logic                         mark_we;
    logic [ffha_pkg::UNIT_W-1:0]  mark_waddr;
    logic                         mark_wdata;

    // Round the byte count up to units; zero bytes take one unit
    assign bytes_round = {1'b0, s_data.request_bytes} + (ffha_pkg::BYTES_W + 1)'(15);
    assign need_next   = (s_data.request_bytes == '0) ? ffha_pkg::NEED_W'(1)
                                                      : bytes_round[ffha_pkg::BYTES_W:4];

    // Header unit in front of the payload being freed
    assign funit      = offset_reg[ffha_pkg::OFFS_W-1:ffha_pkg::UNIT_SHIFT]
                        - ffha_pkg::FUNIT_W'(1);
    assign funit_addr = funit[ffha_pkg::UNIT_W-1:0];

    // Split test and remainder header position
    assign rem_unit = ffha_pkg::CALC_W'(cur_reg[ffha_pkg::UNIT_W-1:0])
                      + ffha_pkg::CALC_W'(1) + ffha_pkg::CALC_W'(need_reg);
    assign split    = (ffha_pkg::CALC_W'(size_rd_reg)
                       >= ffha_pkg::CALC_W'(need_reg) + ffha_pkg::CALC_W'(2))
                      && (rem_unit < ffha_pkg::CALC_W'(ffha_pkg::HEAP_UNITS));
    assign rem_addr = rem_unit[ffha_pkg::UNIT_W-1:0];

    assign cur_plus1 = cur_reg + ffha_pkg::LINK_W'(1);
    assign grant_off = ffha_pkg::OFFS_W'({cur_plus1, {ffha_pkg::UNIT_SHIFT{1'b0}}});

    // Latch the request
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg   <= s_data.kind;
            need_reg   <= need_next;
            offset_reg <= s_data.payload_offset;
        end
    end

    // Walk address: start at the list head, then follow the link just read
    assign rd_en    = cmd.walk_start | cmd.walk_next;
    assign rd_addr  = cmd.walk_start ? free_head_reg[ffha_pkg::UNIT_W-1:0]
                                     : link_rd_reg[ffha_pkg::UNIT_W-1:0];
    assign cur_next = cmd.walk_start ? free_head_reg : link_rd_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cur_reg  <= cur_next;
            prev_reg <= cmd.walk_start ? ffha_pkg::NO_LINK : cur_reg;
            step_reg <= cmd.walk_start ? '0 : step_reg + ffha_pkg::LINK_W'(1);
        end
        if (cmd.commit_a) begin
            repl_reg  <= split ? ffha_pkg::LINK_W'(rem_addr) : link_rd_reg;
            split_reg <= split;
        end
    end

    // Header reads; unit 0 reads its reset header until first written
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (rd_addr == '0 && !size0_set_reg) begin
                size_rd_reg <= ffha_pkg::SIZE0_RESET;
            end else begin
                size_rd_reg <= size_mem[rd_addr];
            end
            if (rd_addr == '0 && !link0_set_reg) begin
                link_rd_reg <= ffha_pkg::NO_LINK;
            end else begin
                link_rd_reg <= link_mem[rd_addr];
            end
        end
    end

    // Mark read for a free request
    always_ff @(posedge aclk) begin
        if (cmd.free_rd) begin
            mark_rd_reg <= mark_mem[funit_addr];
        end
    end

    // Select one write per memory per cycle
    always_comb begin
        size_we    = 1'b0;
        size_waddr = cur_reg[ffha_pkg::UNIT_W-1:0];
        size_wdata = need_reg[ffha_pkg::UNIT_W-1:0];
        link_we    = 1'b0;
        link_waddr = funit_addr;
        link_wdata = free_head_reg;
        mark_we    = 1'b0;
        mark_waddr = clr_cnt_reg;
        mark_wdata = 1'b0;
        if (cmd.clr_en) begin
            mark_we = 1'b1;
        end
        if (cmd.commit_a) begin
            size_we    = split;
            size_waddr = rem_addr;
            size_wdata = size_rd_reg - need_reg[ffha_pkg::UNIT_W-1:0]
                         - ffha_pkg::UNIT_W'(1);
            link_we    = split;
            link_waddr = rem_addr;
            link_wdata = link_rd_reg;
            mark_we    = 1'b1;
            mark_waddr = cur_reg[ffha_pkg::UNIT_W-1:0];
            mark_wdata = 1'b1;
        end
        if (cmd.commit_b) begin
            size_we    = split_reg;
            link_we    = (prev_reg != ffha_pkg::NO_LINK);
            link_waddr = prev_reg[ffha_pkg::UNIT_W-1:0];
            link_wdata = repl_reg;
        end
        if (cmd.free_commit) begin
            link_we    = 1'b1;
            mark_we    = 1'b1;
            mark_waddr = funit_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_waddr] <= size_wdata;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
    end

    // List head, clearing counter and unit-0 written flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            clr_cnt_reg   <= '0;
            size0_set_reg <= 1'b0;
            link0_set_reg <= 1'b0;
        end else begin
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + ffha_pkg::UNIT_W'(1);
            end
            if (cmd.commit_b && prev_reg == ffha_pkg::NO_LINK) begin
                free_head_reg <= repl_reg;
            end else if (cmd.free_commit) begin
                free_head_reg <= ffha_pkg::LINK_W'(funit_addr);
            end
            if (size_we && size_waddr == '0) begin
                size0_set_reg <= 1'b1;
            end
            if (link_we && link_waddr == '0) begin
                link0_set_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.res_we) begin
            res_status_reg <= cmd.res_status;
            res_offset_reg <= cmd.res_grant ? grant_off : '0;
        end
    end

    assign res_data.status         = res_status_reg;
    assign res_data.granted_offset = res_offset_reg;

    // Status to the controller
    assign sts.clr_done = (clr_cnt_reg == ffha_pkg::UNIT_W'(ffha_pkg::HEAP_UNITS - 1));
    assign sts.is_free  = (kind_reg == ffha_pkg::KIND_FREE);
    assign sts.off_zero = (offset_reg == '0);
    assign sts.off_bad  = (offset_reg[ffha_pkg::UNIT_SHIFT-1:0] != '0)
                          || (ffha_pkg::LINK_W'(funit) >= ffha_pkg::LINK_W'(ffha_pkg::HEAP_UNITS));
    assign sts.walk_end = (cur_reg >= ffha_pkg::LINK_W'(ffha_pkg::HEAP_UNITS))
                          || (step_reg >= ffha_pkg::LINK_W'(ffha_pkg::HEAP_UNITS));
    assign sts.fits     = (ffha_pkg::NEED_W'(size_rd_reg) >= need_reg);
    assign sts.mark_set = mark_rd_reg;

`ifndef SYNTHESIS
    a_commit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_a |-> (ffha_pkg::NEED_W'(size_rd_reg) >= need_reg))
        else $error("block committed without room for the request");

    a_commit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_b |-> $past(cmd.commit_a))
        else $error("list relink without a preceding split step");

    a_free_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.free_commit |-> mark_rd_reg)
        else $error("block pushed on the list without an in-use mark");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit_b || cmd.free_commit) |=> (free_head_reg <= ffha_pkg::NO_LINK))
        else $error("free list head out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the heap allocator: mark clearing after reset, request
// decode, list walk, split/relink commit, free check and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               out_free,
    input  wire ffha_pkg::dp_sts_t  sts,
    output ffha_pkg::dp_cmd_t       cmd,
    output logic                    s_ready
);

    ffha_pkg::state_t state_reg;
    ffha_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        cmd            = '0;
        cmd.res_status = ffha_pkg::STAT_OK;
        state_next     = state_reg;
        s_ready        = 1'b0;
        case (state_reg)
            ffha_pkg::S_CLEAR: begin
                // sweep the in-use marks, one unit a cycle
                cmd.clr_en = 1'b1;
                if (sts.clr_done) begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            ffha_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ffha_pkg::S_DECODE;
                end
            end
            ffha_pkg::S_DECODE: begin
                if (!sts.is_free) begin
                    cmd.walk_start = 1'b1;
                    state_next     = ffha_pkg::S_WALK;
                end else if (sts.off_zero) begin
                    cmd.res_we = 1'b1;
                    state_next = ffha_pkg::S_DONE;
                end else if (sts.off_bad) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ffha_pkg::STAT_BADFREE;
                    state_next     = ffha_pkg::S_DONE;
                end else begin
                    cmd.free_rd = 1'b1;
                    state_next  = ffha_pkg::S_FREE_CHK;
                end
            end
            ffha_pkg::S_WALK: begin
                // one list entry per cycle
                if (sts.walk_end) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ffha_pkg::STAT_NOFIT;
                    state_next     = ffha_pkg::S_DONE;
                end else if (sts.fits) begin
                    state_next = ffha_pkg::S_SPLIT;
                end else begin
                    cmd.walk_next = 1'b1;
                end
            end
            ffha_pkg::S_SPLIT: begin
                cmd.commit_a = 1'b1;
                state_next   = ffha_pkg::S_LINK;
            end
            ffha_pkg::S_LINK: begin
                cmd.commit_b  = 1'b1;
                cmd.res_we    = 1'b1;
                cmd.res_grant = 1'b1;
                state_next    = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_FREE_CHK: begin
                cmd.res_we = 1'b1;
                if (sts.mark_set) begin
                    cmd.free_commit = 1'b1;
                end else begin
                    cmd.res_status = ffha_pkg::STAT_BADFREE;
                end
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: test/tb_first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_core
// Self-checking bench for the first-fit heap allocator. A scripted table of
// requests runs first: reset state, null, misaligned, unmarked and double
// frees, requests that cannot fit, exact fits and splits. Random
// allocate/free traffic against a running set of live grants follows. Each
// result is checked against the table's expectation for typed rows, else
// against an in-bench model of the heap, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_first_fit_heap_allocator_core;

    localparam int RANDOM_ITEMS = 1880;
    localparam int SCRIPT_ROWS  = 21;

    typedef struct packed {
        ffha_pkg::kind_t                kind;
        logic [ffha_pkg::BYTES_W-1:0]   bytes;
        logic [ffha_pkg::OFFS_W-1:0]    offs;
        logic                           typed;
        ffha_pkg::status_t              st;
        logic [ffha_pkg::OFFS_W-1:0]    grant;
    } script_row_t;

    // Scripted requests; typed rows carry their own expectation
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{ffha_pkg::KIND_ALLOC, 19'd0,      18'd0,      1'b1, ffha_pkg::STAT_OK,      18'd16},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd0,      1'b1, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd8,      1'b1, ffha_pkg::STAT_BADFREE, 18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd32,     1'b1, ffha_pkg::STAT_BADFREE, 18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd262143, 1'b1, ffha_pkg::STAT_BADFREE, 18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd262128, 1'b1, ffha_pkg::STAT_BADFREE, 18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd262144, 18'd0,      1'b1, ffha_pkg::STAT_NOFIT,   18'd0},
        '{ffha_pkg::KIND_FREE,  19'd262144, 18'd16,     1'b1, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd16,     1'b1, ffha_pkg::STAT_BADFREE, 18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd17,     18'd262143, 1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd1,      18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd262048, 18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd0,      18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd96,     1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd262032, 18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd96,     1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd48,     1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_FREE,  19'd0,      18'd16,     1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd20,     18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd33,     18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0},
        '{ffha_pkg::KIND_ALLOC, 19'd131072, 18'd0,      1'b0, ffha_pkg::STAT_OK,      18'd0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    ffha_pkg::in_item_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    ffha_pkg::out_item_t  m_data;

    // Heap model state
    logic [ffha_pkg::UNIT_W-1:0]  heap_size   [ffha_pkg::HEAP_UNITS];
    logic [ffha_pkg::LINK_W-1:0]  heap_link   [ffha_pkg::HEAP_UNITS];
    logic                         heap_marked [ffha_pkg::HEAP_UNITS];
    logic [ffha_pkg::LINK_W-1:0]  heap_head;

    ffha_pkg::out_item_t          owed_results [$];
    logic [ffha_pkg::OFFS_W-1:0]  live_grants [$];
    logic [ffha_pkg::OFFS_W-1:0]  last_freed;
    int                           error_count;

    first_fit_heap_allocator_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #250_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(string what, int got_v, int want_v);
        $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got_v, want_v);
        error_count++;
    endtask

    // Put the heap model into its reset state: one free block over the heap
    function automatic void heap_clear();
        for (int i = 0; i < ffha_pkg::HEAP_UNITS; i++) begin
            heap_size[i]   = '0;
            heap_link[i]   = '0;
            heap_marked[i] = 1'b0;
        end
        heap_size[0] = ffha_pkg::UNIT_W'(ffha_pkg::HEAP_UNITS - 1);
        heap_link[0] = ffha_pkg::NO_LINK;
        heap_head    = '0;
    endfunction

    // Apply one request to the heap model and return its result
    function automatic ffha_pkg::out_item_t heap_outcome(ffha_pkg::in_item_t req);
        ffha_pkg::out_item_t res;
        int need;
        int cur;
        int prev;
        int steps;
        int blk;
        int rest;
        int repl;
        int unit;
        res.status         = ffha_pkg::STAT_OK;
        res.granted_offset = '0;
        if (req.kind == ffha_pkg::KIND_ALLOC) begin
            res.status = ffha_pkg::STAT_NOFIT;
            need  = (req.request_bytes == 0) ? 1 : (int'(req.request_bytes) + 15) >> 4;
            prev  = ffha_pkg::HEAP_UNITS;
            cur   = int'(heap_head);
            steps = 0;
            // Walk the list and take the first block that fits
            while (cur < ffha_pkg::HEAP_UNITS && steps < ffha_pkg::HEAP_UNITS) begin
                blk = int'(heap_size[cur]);
                if (blk >= need) begin
                    repl = int'(heap_link[cur]);
                    rest = cur + 1 + need;
                    // Split off the remainder when it holds a header and a unit
                    if (blk >= need + 2 && rest < ffha_pkg::HEAP_UNITS) begin
                        heap_size[rest] = ffha_pkg::UNIT_W'(blk - need - 1);
                        heap_link[rest] = heap_link[cur];
                        repl            = rest;
                        heap_size[cur]  = ffha_pkg::UNIT_W'(need);
                    end
                    if (prev == ffha_pkg::HEAP_UNITS) begin
                        heap_head = ffha_pkg::LINK_W'(repl);
                    end else begin
                        heap_link[prev] = ffha_pkg::LINK_W'(repl);
                    end
                    heap_marked[cur]   = 1'b1;
                    res.status         = ffha_pkg::STAT_OK;
                    res.granted_offset = ffha_pkg::OFFS_W'((cur + 1) * 16);
                    break;
                end
                prev = cur;
                cur  = int'(heap_link[cur]);
                steps++;
            end
        end else if (req.payload_offset != 0) begin
            if (req.payload_offset[3:0] != 4'd0) begin
                res.status = ffha_pkg::STAT_BADFREE;
            end else begin
                unit = int'(req.payload_offset >> 4) - 1;
                if (unit >= ffha_pkg::HEAP_UNITS || !heap_marked[unit]) begin
                    res.status = ffha_pkg::STAT_BADFREE;
                end else begin
                    // Push the block onto the head of the list
                    heap_marked[unit] = 1'b0;
                    heap_link[unit]   = heap_head;
                    heap_head         = ffha_pkg::LINK_W'(unit);
                end
            end
        end
        return res;
    endfunction

    // Idle between requests, with stretches of back-to-back traffic
    function automatic int sender_gap(int n);
        return ((n % 128) < 32) ? 0 : $urandom_range(0, 17);
    endfunction

    // Mostly allocate/free of live grants, some noise frees
    function automatic ffha_pkg::in_item_t random_request();
        ffha_pkg::in_item_t req;
        int pick;
        int free_pct;
        req.kind           = ffha_pkg::KIND_ALLOC;
        req.request_bytes  = ffha_pkg::BYTES_W'($urandom_range(0, 262144));
        req.payload_offset = ffha_pkg::OFFS_W'($urandom_range(0, 262143));
        pick     = $urandom_range(0, 99);
        free_pct = (live_grants.size() > 48) ? 60 : 35;
        if (pick < 8) begin
            req.kind = ffha_pkg::KIND_FREE;
            case ($urandom_range(0, 3))
                0: req.payload_offset = '0;
                1: req.payload_offset[3:0] = 4'($urandom_range(1, 15));
                2: req.payload_offset[3:0] = 4'd0;
                default: req.payload_offset = last_freed;
            endcase
        end else if (pick < 8 + free_pct && live_grants.size() != 0) begin
            req.kind           = ffha_pkg::KIND_FREE;
            req.payload_offset = live_grants[$urandom_range(0, live_grants.size() - 1)];
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                req.request_bytes = ffha_pkg::BYTES_W'($urandom_range(0, 128));
            end else if (pick < 95) begin
                req.request_bytes = ffha_pkg::BYTES_W'($urandom_range(129, 2048));
            end else if (pick < 99) begin
                req.request_bytes = ffha_pkg::BYTES_W'($urandom_range(2049, 16384));
            end else begin
                req.request_bytes = ffha_pkg::BYTES_W'($urandom_range(16385, 262144));
            end
        end
        return req;
    endfunction

    // Present one request, hold it until taken, then log its expected result
    task automatic send_request(ffha_pkg::in_item_t req, int gap, logic typed,
                                ffha_pkg::out_item_t typed_res);
        ffha_pkg::out_item_t pred;
        int i;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pred = heap_outcome(req);
        owed_results.push_back(typed ? typed_res : pred);
        // Track live grants for later frees
        if (req.kind == ffha_pkg::KIND_ALLOC && pred.status == ffha_pkg::STAT_OK) begin
            live_grants.push_back(pred.granted_offset);
        end else if (req.kind == ffha_pkg::KIND_FREE && pred.status == ffha_pkg::STAT_OK
                     && req.payload_offset != 0) begin
            last_freed = req.payload_offset;
            for (i = 0; i < live_grants.size(); i++) begin
                if (live_grants[i] == req.payload_offset) begin
                    live_grants.delete(i);
                    break;
                end
            end
        end
    endtask

    // Result side: random stalls, compare each taken result with the oldest expectation
    initial begin
        int stall;
        int seen;
        ffha_pkg::out_item_t want;
        m_ready <= 1'b0;
        seen = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = ((seen % 100) >= 70) ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (owed_results.size() == 0) begin
                report_mismatch("result with nothing expected, status",
                                int'(m_data.status), -1);
            end else begin
                want = owed_results.pop_front();
                if (m_data.status != want.status)
                    report_mismatch("result status", int'(m_data.status),
                                    int'(want.status));
                if (m_data.granted_offset != want.granted_offset)
                    report_mismatch("granted offset", int'(m_data.granted_offset),
                                    int'(want.granted_offset));
            end
            seen++;
        end
    end

    // Request side: reset, scripted table, random traffic, drain
    initial begin
        ffha_pkg::in_item_t req;
        ffha_pkg::out_item_t typed_res;
        int n;
        error_count = 0;
        last_freed  = 18'd16;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        heap_clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        n = 0;
        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            req.kind                 = SCRIPT[i].kind;
            req.request_bytes        = SCRIPT[i].bytes;
            req.payload_offset       = SCRIPT[i].offs;
            typed_res.status         = SCRIPT[i].st;
            typed_res.granted_offset = SCRIPT[i].grant;
            send_request(req, sender_gap(n), SCRIPT[i].typed, typed_res);
            n++;
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_request(random_request(), sender_gap(n), 1'b0, typed_res);
            n++;
        end
        s_valid <= 1'b0;

        // Drain, then watch for stray results
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/ffha_pkg.sv
sv/ffha_datapath.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator_core.sv
test/tb_first_fit_heap_allocator_core.sv
